[rtl/rectangle_set_difference_unit_defines.svh]
// Assertion macros for the rectangle set difference unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef RECTANGLE_SET_DIFFERENCE_UNIT_DEFINES_SVH
`define RECTANGLE_SET_DIFFERENCE_UNIT_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define RSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define RSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/rsd_pkg.sv]
// Shared types and constants of the rectangle set difference unit.
// No dependencies; imported by every module of the block.
package rsd_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FIELD_BITS     = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_SUBTRACT = 2'd1,
    KIND_EMIT     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB_READ,
    ST_SUB_CALC,
    ST_SUB_WRITE,
    ST_EMIT_READ,
    ST_EMIT_OUT
  } back_state_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [FIELD_BITS-1:0] left_edge;
    logic signed [FIELD_BITS-1:0] bottom_edge;
    logic signed [FIELD_BITS-1:0] right_edge;
    logic signed [FIELD_BITS-1:0] top_edge;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] out_left;
    logic signed [FIELD_BITS-1:0] out_bottom;
    logic signed [FIELD_BITS-1:0] out_right;
    logic signed [FIELD_BITS-1:0] out_top;
    logic                         out_valid;
    logic                         out_last;
    logic                         overflow;
  } out_t;

  // Classified command; coordinates already reduced to the coordinate width
  // and sign-extended back to the field width.
  typedef struct packed {
    kind_e                        kind;
    logic signed [FIELD_BITS-1:0] left_edge;
    logic signed [FIELD_BITS-1:0] bottom_edge;
    logic signed [FIELD_BITS-1:0] right_edge;
    logic signed [FIELD_BITS-1:0] top_edge;
  } cmd_t;

endpackage

[rtl/rsd_front.sv]
// Front end: accepts input items, reduces coordinates, drops empty loads and unknown kinds.
// Depends on rsd_pkg; feeds rsd_queue.
module rsd_front import rsd_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  input  logic q_full_i,
  output logic push_o,
  output cmd_t cmd_o
);

  logic signed [CoordBits-1:0] l_c, b_c, r_c, t_c;
  logic                        keep;

  assign l_c = CoordBits'(in_item_i.left_edge);
  assign b_c = CoordBits'(in_item_i.bottom_edge);
  assign r_c = CoordBits'(in_item_i.right_edge);
  assign t_c = CoordBits'(in_item_i.top_edge);

  always_comb begin
    cmd_o.left_edge   = FIELD_BITS'(l_c);
    cmd_o.bottom_edge = FIELD_BITS'(b_c);
    cmd_o.right_edge  = FIELD_BITS'(r_c);
    cmd_o.top_edge    = FIELD_BITS'(t_c);
    cmd_o.kind        = KIND_LOAD;
    keep              = 1'b0;
    unique case (in_item_i.kind)
      KIND_LOAD: begin
        // drop empty rectangles here
        keep = (l_c < r_c) && (b_c < t_c);
      end
      KIND_SUBTRACT: begin
        cmd_o.kind = KIND_SUBTRACT;
        keep       = 1'b1;
      end
      KIND_EMIT: begin
        cmd_o.kind = KIND_EMIT;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

[rtl/rsd_queue.sv]
// Short command queue between the front end and the back end.
// Depends on rsd_pkg for the command type and depth.
module rsd_queue import rsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[rtl/rsd_back.sv]
// Back end: rectangle store in two banks, subtract and emit sequencer,
// output register. Depends on rsd_pkg; drains rsd_queue.
module rsd_back import rsd_pkg::*; #(
  parameter int unsigned Capacity  = CAPACITY_DEF,
  parameter int unsigned CoordBits = COORD_BITS_DEF,
  localparam int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_item_o,
  output logic [CntW-1:0] rect_count_o
);

  localparam int unsigned IdxW  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned WordW = 4 * CoordBits;
  localparam int unsigned Depth = 2 ** (IdxW + 1);

  back_state_e state_q, state_d;

  logic [WordW-1:0] rect_mem [Depth];
  logic [WordW-1:0] rd_data_q;
  logic             rd_en, wr_en;
  logic [IdxW:0]    rd_addr, wr_addr;
  logic [WordW-1:0] wr_data;

  cmd_t             cmd_q, cmd_d;
  logic [CntW-1:0]  count_q, count_d, idx_q, idx_d, n_q, n_d, idx_inc;
  logic             bank_q, bank_d, ovf_q, ovf_d;
  logic [WordW-1:0] piece_q [4];
  logic [WordW-1:0] piece_d [4];
  logic [3:0]       pmask_q, pmask_d;
  logic [1:0]       sel;
  logic             last_src;

  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d, out_free;

  logic signed [CoordBits-1:0] al, ab, ar, at, ql, qb, qr, qt, il, ib, ir, it;

  assign al = rd_data_q[4*CoordBits-1 -: CoordBits];
  assign ab = rd_data_q[3*CoordBits-1 -: CoordBits];
  assign ar = rd_data_q[2*CoordBits-1 -: CoordBits];
  assign at = rd_data_q[CoordBits-1 -: CoordBits];
  assign ql = CoordBits'(cmd_q.left_edge);
  assign qb = CoordBits'(cmd_q.bottom_edge);
  assign qr = CoordBits'(cmd_q.right_edge);
  assign qt = CoordBits'(cmd_q.top_edge);
  assign il = (al > ql) ? al : ql;
  assign ib = (ab > qb) ? ab : qb;
  assign ir = (ar < qr) ? ar : qr;
  assign it = (at < qt) ? at : qt;

  assign idx_inc  = idx_q + CntW'(1);
  assign last_src = (idx_inc == count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    count_d     = count_q;
    idx_d       = idx_q;
    n_d         = n_q;
    bank_d      = bank_q;
    ovf_d       = ovf_q;
    piece_d     = piece_q;
    pmask_d     = pmask_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = {bank_q, idx_q[IdxW-1:0]};
    wr_en       = 1'b0;
    wr_addr     = {bank_q, count_q[IdxW-1:0]};
    wr_data     = {CoordBits'(cmd_i.left_edge), CoordBits'(cmd_i.bottom_edge),
                   CoordBits'(cmd_i.right_edge), CoordBits'(cmd_i.top_edge)};
    sel         = 2'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            KIND_LOAD: begin
              cmd_pop_o = 1'b1;
              if (count_q == CntW'(Capacity)) begin
                ovf_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            KIND_SUBTRACT: begin
              cmd_pop_o = 1'b1;
              cmd_d     = cmd_i;
              idx_d     = '0;
              n_d       = '0;
              if (count_q == '0) begin
                bank_d = ~bank_q;
              end else begin
                state_d = ST_SUB_READ;
              end
            end
            KIND_EMIT: begin
              idx_d = '0;
              if (count_q != '0) begin
                cmd_pop_o = 1'b1;
                state_d   = ST_EMIT_READ;
              end else if (out_free) begin
                // empty list: one marker item, then clear the flag
                cmd_pop_o         = 1'b1;
                out_d             = '0;
                out_d.out_last    = 1'b1;
                out_d.overflow    = ovf_q;
                out_valid_d       = 1'b1;
                ovf_d             = 1'b0;
              end
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      ST_SUB_READ: begin
        rd_en   = 1'b1;
        state_d = ST_SUB_CALC;
      end
      ST_SUB_CALC: begin
        piece_d[0] = {al, it, ar, at};
        piece_d[1] = {al, ab, ar, ib};
        piece_d[2] = {al, ib, il, it};
        piece_d[3] = {ir, ib, ar, it};
        if (il >= ir || ib >= it) begin
          // no overlap: keep the rectangle as it is
          piece_d[0] = rd_data_q;
          pmask_d    = 4'b0001;
          state_d    = ST_SUB_WRITE;
        end else begin
          pmask_d = {ir < ar, al < il, ab < ib, it < at};
          if (pmask_d != 4'b0000) begin
            state_d = ST_SUB_WRITE;
          end else if (last_src) begin
            bank_d  = ~bank_q;
            count_d = n_q;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_SUB_READ;
          end
        end
      end
      ST_SUB_WRITE: begin
        priority if (pmask_q[0]) sel = 2'd0;
        else if (pmask_q[1])     sel = 2'd1;
        else if (pmask_q[2])     sel = 2'd2;
        else                     sel = 2'd3;
        wr_addr = {~bank_q, n_q[IdxW-1:0]};
        wr_data = piece_q[sel];
        if (n_q < CntW'(Capacity)) begin
          wr_en = 1'b1;
          n_d   = n_q + CntW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        pmask_d = pmask_q & ~(4'b0001 << sel);
        if (pmask_d == 4'b0000) begin
          if (last_src) begin
            bank_d  = ~bank_q;
            count_d = n_d;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_SUB_READ;
          end
        end
      end
      ST_EMIT_READ: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_d.out_left   = FIELD_BITS'(al);
          out_d.out_bottom = FIELD_BITS'(ab);
          out_d.out_right  = FIELD_BITS'(ar);
          out_d.out_top    = FIELD_BITS'(at);
          out_d.out_valid  = 1'b1;
          out_d.out_last   = last_src;
          out_d.overflow   = ovf_q;
          out_valid_d      = 1'b1;
          if (last_src) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_EMIT_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      bank_q      <= 1'b0;
      ovf_q       <= 1'b0;
      pmask_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      bank_q      <= bank_d;
      ovf_q       <= ovf_d;
      pmask_q     <= pmask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    piece_q <= piece_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rect_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= rect_mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_q;
  assign rect_count_o = count_q;

endmodule

[rtl/rectangle_set_difference_unit.sv]
// Rectangle set difference unit: ordered rectangle list with subtract, emit
// and clear. Uses rsd_pkg, rsd_front, rsd_queue, rsd_back and the macros header.
// Input channel in_valid_i / in_stall_o / in_item_i: load appends, subtract
// cuts a rectangle out of every stored one, emit lists the store and clears
// it; empty loads and unknown kinds are dropped.
// Output channel out_valid_o / out_stall_i / out_item_o: one item per stored
// rectangle on emit, the final one marked last; an empty list gives a single
// item with out_valid clear.
// The front end takes an item per cycle into a four-deep queue and stalls only
// while it is full. The back end owns the store (one memory, two banks, one
// write and one read port with registered read data). With the back end idle:
//   load      written to the current bank straight from the queue head;
//   subtract  reads each stored rectangle, computes its pieces and writes
//             each to the other bank (a rectangle kept whole is one piece);
//   emit      reads each stored rectangle, then loads it into the output
//             register (memory read, then output load); an empty list gives
//             its single item directly. A new command waits until idle.
// Reset empties the list and clears the overflow flag, not the memory. An
// output stall holds the output register, then the back end; the queue then
// fills and the input stalls.
module rectangle_set_difference_unit import rsd_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

`include "rectangle_set_difference_unit_defines.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // front end to queue
  logic push, q_full;
  cmd_t push_cmd;

  // queue to back end
  logic pop, q_empty;
  cmd_t head_cmd;

  logic [CntW-1:0] rect_count;

  // empty-list marker on the output, and its coordinates all zero
  logic marker_item, marker_zero;

  rsd_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  rsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head_cmd)
  );

  rsd_back #(
    .Capacity (CAPACITY),
    .CoordBits(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .rect_count_o(rect_count)
  );

  assign marker_item = out_valid_o && !out_item_o.out_valid;
  assign marker_zero = (out_item_o.out_left == '0) && (out_item_o.out_bottom == '0) &&
                       (out_item_o.out_right == '0) && (out_item_o.out_top == '0);

  // The list never holds more than its capacity.
  `RSD_ASSERT_ALWAYS(a_count_bound, rect_count <= CntW'(CAPACITY), "list count above capacity")

  // An item without a rectangle is only the empty-list marker, always last.
  `RSD_ASSERT_IMPLIES(a_empty_is_last, marker_item, out_item_o.out_last, "marker not last")

  // The empty-list marker carries zero coordinates.
  `RSD_ASSERT_IMPLIES(a_empty_zero, marker_item, marker_zero, "marker has coordinates")

endmodule

[sim/rectangle_set_difference_unit_test.sv]
// Self-checking testbench of the rectangle set difference unit.
// Depends on rsd_pkg and the unit itself; predicts every emitted rectangle
// from its own copy of the list and checks results in order.
module rectangle_set_difference_unit_test;
  import rsd_pkg::*;

  localparam int unsigned COORD_W     = COORD_BITS_DEF;
  localparam int unsigned LIST_SLOTS  = CAPACITY_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  // One stored rectangle of the predicted list; int keeps compares signed.
  typedef struct packed {
    int l;
    int b;
    int r;
    int t;
  } box_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_item_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_item_o;

  // Predicted list, scratch list for cuts, and results still owed.
  box_t        held_boxes[$];
  box_t        cut_boxes[$];
  bit          drop_flag;
  out_t        owed_rects[$];

  bit          steady_flow;
  int unsigned items_sent;
  int unsigned rects_checked;
  int unsigned empty_lists;
  int unsigned drop_reports;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  rectangle_set_difference_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Reduce a field to the coordinate width and sign-extend it again.
  function automatic int to_coord(logic [FIELD_BITS-1:0] v);
    logic [FIELD_BITS-1:0] s;
    s = v << (FIELD_BITS - COORD_W);
    return $signed(s) >>> (FIELD_BITS - COORD_W);
  endfunction

  function automatic box_t mk_box(int l, int b, int r, int t);
    box_t bx;
    bx.l = l;
    bx.b = b;
    bx.r = r;
    bx.t = t;
    return bx;
  endfunction

  // Append a piece to the cut list; drop it once the list is full.
  function automatic void add_piece(box_t bx);
    if (cut_boxes.size() >= LIST_SLOTS) begin
      drop_flag = 1'b1;
    end else begin
      cut_boxes = {cut_boxes, bx};
    end
  endfunction

  // Remove the hole from every held rectangle, keeping list order.
  function automatic void cut_hole(box_t q);
    box_t a;
    int   il, ib, ir, it;
    cut_boxes.delete();
    foreach (held_boxes[i]) begin
      a  = held_boxes[i];
      il = (a.l > q.l) ? a.l : q.l;
      ib = (a.b > q.b) ? a.b : q.b;
      ir = (a.r < q.r) ? a.r : q.r;
      it = (a.t < q.t) ? a.t : q.t;
      if (il >= ir || ib >= it) begin
        // no overlap: keep it whole
        add_piece(a);
      end else begin
        // pieces go top, bottom, left, right
        if (it < a.t) add_piece(mk_box(a.l, it, a.r, a.t));
        if (a.b < ib) add_piece(mk_box(a.l, a.b, a.r, ib));
        if (a.l < il) add_piece(mk_box(a.l, ib, il, it));
        if (ir < a.r) add_piece(mk_box(ir, ib, a.r, it));
      end
    end
    held_boxes = cut_boxes;
  endfunction

  // List the held rectangles as owed results, then clear list and flag.
  function automatic void list_out();
    out_t o;
    if (held_boxes.size() == 0) begin
      o          = '0;
      o.out_last = 1'b1;
      o.overflow = drop_flag;
      owed_rects = {owed_rects, o};
    end
    foreach (held_boxes[i]) begin
      o            = '0;
      o.out_left   = held_boxes[i].l;
      o.out_bottom = held_boxes[i].b;
      o.out_right  = held_boxes[i].r;
      o.out_top    = held_boxes[i].t;
      o.out_valid  = 1'b1;
      o.out_last   = (i == held_boxes.size() - 1);
      o.overflow   = drop_flag;
      owed_rects   = {owed_rects, o};
    end
    held_boxes.delete();
    drop_flag = 1'b0;
  endfunction

  // Apply one accepted item to the predicted list.
  function automatic void predict_item(in_t item);
    box_t q;
    q = mk_box(to_coord(item.left_edge), to_coord(item.bottom_edge),
               to_coord(item.right_edge), to_coord(item.top_edge));
    case (item.kind)
      KIND_LOAD: begin
        // degenerate rectangles vanish without a trace
        if (q.l < q.r && q.b < q.t) begin
          if (held_boxes.size() >= LIST_SLOTS) drop_flag = 1'b1;
          else held_boxes = {held_boxes, q};
        end
      end
      KIND_SUBTRACT: cut_hole(q);
      KIND_EMIT:     list_out();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic void note_mismatch(string what, out_t want, out_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch (%s) at %0t", what, $realtime);
      $display("  expected l=%0d b=%0d r=%0d t=%0d valid=%b last=%b ovf=%b",
               want.out_left, want.out_bottom, want.out_right, want.out_top,
               want.out_valid, want.out_last, want.overflow);
      $display("  actual   l=%0d b=%0d r=%0d t=%0d valid=%b last=%b ovf=%b",
               got.out_left, got.out_bottom, got.out_right, got.out_top,
               got.out_valid, got.out_last, got.overflow);
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (owed_rects.size() == 0) begin
      note_mismatch("no result owed", '0, got);
      return;
    end
    want = owed_rects.pop_front();
    rects_checked++;
    if (!want.out_valid) empty_lists++;
    if (want.overflow && want.out_last) drop_reports++;
    if (got.out_left   !== want.out_left   || got.out_bottom !== want.out_bottom ||
        got.out_right  !== want.out_right  || got.out_top    !== want.out_top    ||
        got.out_valid  !== want.out_valid  || got.out_last   !== want.out_last   ||
        got.overflow   !== want.overflow) begin
      note_mismatch("field", want, got);
    end
  endfunction

  // Take each result at the edge where it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
  end

  // Hold the output off at random, except in the steady stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(99) < 14);
  end

  // Count cycles in which neither channel moves; give up past the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic in_t make_item(logic [1:0] kind, int l, int b, int r, int t);
    in_t it;
    it.kind        = kind;
    it.left_edge   = l;
    it.bottom_edge = b;
    it.right_edge  = r;
    it.top_edge    = t;
    return it;
  endfunction

  // Send one item: idle at random first, then hold it until accepted.
  task automatic send_item(in_t item);
    while (!steady_flow && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Small rectangle near an origin; a few come out empty or inverted.
  function automatic in_t random_rect(logic [1:0] kind, int origin);
    int l, b, w, h;
    l = origin + int'($urandom_range(48)) - 24;
    b = origin + int'($urandom_range(48)) - 24;
    w = ($urandom_range(99) < 6) ? -int'($urandom_range(2)) : int'($urandom_range(1, 24));
    h = ($urandom_range(99) < 6) ? -int'($urandom_range(2)) : int'($urandom_range(1, 24));
    return make_item(kind, l, b, l + w, b + h);
  endfunction

  // Noise: every field random over its whole width, any kind.
  function automatic in_t noise_item();
    logic [1:0] k;
    k = 2'($urandom_range(3));
    return make_item(k, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // One batch: loads and cuts around a common origin, mixed with noise, closed by an emit.
  task automatic run_batch();
    int          origin;
    int unsigned pick;
    case ($urandom_range(9))
      0:       origin = 32'h7FFF_FFF0;
      1:       origin = 32'h8000_0010;
      2:       origin = $urandom;
      default: origin = 0;
    endcase
    repeat ($urandom_range(3, 12)) begin
      pick = $urandom_range(99);
      if (pick < 55)      send_item(random_rect(KIND_LOAD, origin));
      else if (pick < 92) send_item(random_rect(KIND_SUBTRACT, origin));
      else                send_item(noise_item());
    end
    send_item(random_rect(KIND_EMIT, $urandom));
  endtask

  // Extremes, degenerate shapes, unused kind, and each kind of cut.
  task automatic test_directed_cases();
    send_item(make_item(KIND_EMIT, 0, 0, 0, 0));             // empty list
    send_item(make_item(KIND_UNUSED, 1, 2, 3, 4));           // dropped kind
    send_item(make_item(KIND_LOAD, 5, 0, 5, 10));            // zero width
    send_item(make_item(KIND_LOAD, 0, 9, 10, 3));            // inverted height
    send_item(make_item(KIND_LOAD, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));      // widest rectangle
    send_item(make_item(KIND_LOAD, 0, 0, 10, 10));
    send_item(make_item(KIND_SUBTRACT, 5, 5, 5, 8));         // degenerate hole
    send_item(make_item(KIND_SUBTRACT, 100, 100, 200, 200)); // misses the small one
    send_item(make_item(KIND_SUBTRACT, 10, 0, 20, 10));      // shares an edge only
    send_item(make_item(KIND_SUBTRACT, 2, 2, 4, 4));         // hole: four pieces each
    send_item(make_item(KIND_SUBTRACT, -5, 8, 3, 30));       // clips a corner
    send_item(make_item(KIND_EMIT, 0, 0, 0, 0));
    send_item(make_item(KIND_LOAD, -7, -7, 7, 7));
    send_item(make_item(KIND_SUBTRACT, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));      // removes everything
    send_item(make_item(KIND_EMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Fill the list with pieces, then push past it by load and by cut.
  task automatic test_capacity_limits();
    repeat (4) send_item(make_item(KIND_LOAD, 0, 0, 10, 10));
    send_item(make_item(KIND_SUBTRACT, 2, 2, 4, 4));         // exactly full
    send_item(make_item(KIND_LOAD, 20, 20, 30, 30));         // dropped: full
    send_item(make_item(KIND_EMIT, 0, 0, 0, 0));
    send_item(make_item(KIND_EMIT, 0, 0, 0, 0));             // flag now clear
    repeat (5) send_item(make_item(KIND_LOAD, -10, -10, 0, 0));
    send_item(make_item(KIND_SUBTRACT, -8, -8, -2, -2));     // too many pieces
    send_item(make_item(KIND_EMIT, 0, 0, 0, 0));
  endtask

  task automatic test_random_mix(int unsigned goal);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < goal) run_batch();
  endtask

  // Same mix with neither side idling, so the queue runs full.
  task automatic test_steady_flow(int unsigned goal);
    steady_flow = 1'b1;
    test_random_mix(goal);
    steady_flow = 1'b0;
  endtask

  initial begin
    steady_flow   = 1'b0;
    drop_flag     = 1'b0;
    items_sent    = 0;
    rects_checked = 0;
    empty_lists   = 0;
    drop_reports  = 0;
    mismatches    = 0;

    // Hold reset low from the start, then release it on a falling edge.
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_capacity_limits();
    test_random_mix(180);
    test_steady_flow(50);
    test_random_mix(50);
    in_valid_i <= 1'b0;

    // Drain: wait for every owed result, then watch for strays.
    while (owed_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items; checked %0d results, %0d of them empty lists.",
             items_sent, rects_checked, empty_lists);
    $display("Lists flagged with dropped rectangles: %0d; mismatches: %0d.",
             drop_reports, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
